FILE: src/sqv_pkg.sv
// ----------------------------------------------------------------------------
// Soft square voice package
// Shared constants, operation and register codes, the sequencer state type,
// the semitone table and the elaboration-time build of the waveshaper table.
// ----------------------------------------------------------------------------
package sqv_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SAMPLE_BITS     = 16;
    localparam int SHAPE_DEPTH     = 1024;
    localparam int SHAPE_IDX_BITS  = $clog2(SHAPE_DEPTH);
    localparam int SHAPE_ADDR_BITS = $clog2(SHAPE_DEPTH + 1);
    localparam int LEVEL_BITS      = 16;
    localparam int GAIN_BITS       = 17;
    localparam int FACTOR_BITS     = 16;
    localparam int RATIO_BITS      = 17;
    localparam int NOTE_BITS       = 7;
    localparam int VEL_BITS        = 7;
    localparam int OCT_BITS        = 4;
    localparam int SEMI_BITS       = 4;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;
    localparam int MULT_A_BITS     = 32;
    localparam int MULT_B_BITS     = 17;
    localparam int PROD_BITS       = MULT_A_BITS + MULT_B_BITS;
    localparam int STEP_SHIFT      = 21;
    localparam int WIDE_BITS       = 64;
    localparam int OCT_MAX         = 10;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(65536);

    localparam logic [PHASE_BITS-1:0]  RST_A4_STEP    = PHASE_BITS'(39370534);
    localparam logic [LEVEL_BITS-1:0]  RST_LEVEL_SCALE = LEVEL_BITS'(9830);
    localparam logic [FACTOR_BITS-1:0] RST_DECAY      = FACTOR_BITS'(64881);
    localparam logic [GAIN_BITS-1:0]   RST_THRESHOLD  = GAIN_BITS'(328);

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_NOTE_ON = 2'd1,
        OP_RELEASE = 2'd2,
        OP_OFF     = 2'd3
    } op_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_A4_STEP     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_SCALE = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY       = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ON_STEP,
        S_ON_LEVEL,
        S_SHAPE,
        S_REL,
        S_DECAY,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [OCT_BITS-1:0]  oct;
        logic [SEMI_BITS-1:0] semi;
    } note_split_t;

    typedef logic [SAMPLE_BITS-1:0] shape_table_t [0:SHAPE_DEPTH];

    function automatic note_split_t note_split(input logic [NOTE_BITS-1:0] note);
        note_split_t res;
        logic [NOTE_BITS-1:0] base;
        res.oct = '0;
        for (int k = 1; k <= OCT_MAX; k++) begin
            if (note >= NOTE_BITS'(12 * k)) begin
                res.oct = OCT_BITS'(k);
            end
        end
        base = NOTE_BITS'(res.oct * 12);
        res.semi = SEMI_BITS'(note - base);
        return res;
    endfunction

    function automatic logic [RATIO_BITS-1:0] semitone_ratio(input logic [SEMI_BITS-1:0] semi);
        logic [RATIO_BITS-1:0] r;
        case (semi)
            4'd0:    r = RATIO_BITS'(38968);
            4'd1:    r = RATIO_BITS'(41285);
            4'd2:    r = RATIO_BITS'(43740);
            4'd3:    r = RATIO_BITS'(46341);
            4'd4:    r = RATIO_BITS'(49097);
            4'd5:    r = RATIO_BITS'(52016);
            4'd6:    r = RATIO_BITS'(55109);
            4'd7:    r = RATIO_BITS'(58386);
            4'd8:    r = RATIO_BITS'(61858);
            4'd9:    r = RATIO_BITS'(65536);
            4'd10:   r = RATIO_BITS'(69433);
            4'd11:   r = RATIO_BITS'(73562);
            default: r = '0;
        endcase
        return r;
    endfunction

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
    localparam longint unsigned Q30_LN2     = 64'd744261118;
    localparam longint unsigned SAMPLE_MAX  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    localparam longint unsigned DEPTH_L     = SHAPE_DEPTH;

    // Unsigned quotient by shift and subtract, used only while the table is built.
    function automatic longint unsigned const_div(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine in Q30 by an eight-term series.
    function automatic longint unsigned q30_sin_quarter(input longint unsigned k);
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint unsigned n;
        longint sum;
        a = const_div(k * Q30_HALF_PI, DEPTH_L);
        a2 = (a * a) >> 30;
        term = a;
        sum = longint'(a);
        for (n = 1; n <= 7; n++) begin
            term = const_div((term * a2) >> 30, (64'd2 * n) * (64'd2 * n + 64'd1));
            if (n[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(Q30_ONE)) begin
            sum = longint'(Q30_ONE);
        end
        return longint'(sum);
    endfunction

    // exp(-z) in Q30, splitting off whole multiples of ln 2.
    function automatic longint unsigned q30_exp_neg(input longint unsigned z);
        longint unsigned nn;
        longint unsigned r;
        longint unsigned term;
        longint unsigned i;
        longint sum;
        nn = const_div(z, Q30_LN2);
        r = z - nn * Q30_LN2;
        term = Q30_ONE;
        sum = longint'(Q30_ONE);
        if (nn >= 64'd31) begin
            return 64'd0;
        end
        for (i = 1; i <= 14; i++) begin
            term = const_div((term * r) >> 30, i);
            if (i[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return longint'(sum) >> nn;
    endfunction

    function automatic longint unsigned shape_entry(input longint unsigned k);
        longint unsigned s;
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        longint unsigned t;
        s = q30_sin_quarter(k);
        e = q30_exp_neg(64'd60 * s);
        num = Q30_ONE - e;
        den = Q30_ONE + e;
        t = const_div((num << SAMPLE_BITS) + den, 64'd2 * den);
        if (t > SAMPLE_MAX) begin
            t = SAMPLE_MAX;
        end
        return t;
    endfunction

    function automatic shape_table_t build_shape_table();
        shape_table_t tbl;
        longint unsigned v;
        for (int k = 0; k <= SHAPE_DEPTH; k++) begin
            v = shape_entry(longint'(k));
            tbl[k] = v[SAMPLE_BITS-1:0];
        end
        return tbl;
    endfunction

endpackage

FILE: src/sqv_shape_rom.sv
// ----------------------------------------------------------------------------
// Soft square shape table
// Quarter-wave table of tanh(30*sin(x)) with a registered read port.
// ----------------------------------------------------------------------------
module sqv_shape_rom
    import sqv_pkg::*;
(
    input  logic                       clk,
    input  logic [SHAPE_ADDR_BITS-1:0] addr,
    output logic [SAMPLE_BITS-1:0]     data
);

    localparam shape_table_t SHAPE_TABLE = build_shape_table();

    always_ff @(posedge clk)
    begin
        data <= SHAPE_TABLE[addr];
    end

endmodule

FILE: src/soft_square_voice_with_decay.sv
// ----------------------------------------------------------------------------
// Soft square voice with decay
// Single synthesiser voice: phase accumulator, soft square shape table,
// velocity level and exponential release, all products on one multiplier.
// ----------------------------------------------------------------------------
// A note on runs the step and level states; release and immediate off act in
// idle. An idle-voice tick goes straight to emit, a sounding tick via shape,
// a releasing tick via shape, release and decay (the levelled shape, release
// gain and decay each take one pass through the multiplier).
// The input is ready only while the sequencer waits for an item.
// Reset sets the configuration registers to their defaults and silences the voice.
// ----------------------------------------------------------------------------
module soft_square_voice_with_decay
    import sqv_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [15:0]               s_axis_tdata,   // note_number [6:0], velocity [13:7]
    input  logic [1:0]                s_axis_tuser,   // operation [1:0]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [SAMPLE_BITS-1:0]    m_axis_tdata,   // sample [15:0]
    output logic                      m_axis_tuser,   // voice_active [0]
    output logic                      m_axis_tlast    // note_ended
);

    state_t state_reg, state_next;

    logic [PHASE_BITS-1:0]  a4_reg;
    logic [LEVEL_BITS-1:0]  scale_reg;
    logic [FACTOR_BITS-1:0] decay_reg;
    logic [GAIN_BITS-1:0]   thr_reg;

    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic [PHASE_BITS-1:0]  step_reg, step_next;
    logic [LEVEL_BITS-1:0]  level_reg, level_next;
    logic [GAIN_BITS-1:0]   gain_reg, gain_next;
    logic                   sounding_reg, sounding_next;
    logic [OCT_BITS-1:0]    oct_reg, oct_next;
    logic [SEMI_BITS-1:0]   semi_reg, semi_next;
    logic [VEL_BITS-1:0]    vel_reg, vel_next;
    logic [SAMPLE_BITS-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic                   active_reg, active_next;
    logic                   ended_reg, ended_next;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_active_reg;
    logic                   out_ended_reg;

    logic                       in_xfer;
    logic                       out_load;
    op_t                        in_op;
    logic [NOTE_BITS-1:0]       in_note;
    logic [VEL_BITS-1:0]        in_vel;
    note_split_t                in_split;
    logic [SHAPE_IDX_BITS-1:0]  shape_idx;
    logic [SHAPE_ADDR_BITS-1:0] rom_addr;
    logic [SAMPLE_BITS-1:0]     rom_data;
    logic [MULT_A_BITS-1:0]     mult_a;
    logic [MULT_B_BITS-1:0]     mult_b;
    logic [PROD_BITS-1:0]       product;
    logic [WIDE_BITS-1:0]       step_wide;
    logic [GAIN_BITS-1:0]       gain_decayed;

    assign in_op    = op_t'(s_axis_tuser);
    assign in_note  = s_axis_tdata[NOTE_BITS-1:0];
    assign in_vel   = s_axis_tdata[NOTE_BITS +: VEL_BITS];
    assign in_split = note_split(in_note);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;

    assign shape_idx = phase_reg[PHASE_BITS-3 -: SHAPE_IDX_BITS];
    assign rom_addr  = phase_reg[PHASE_BITS-2]
                     ? SHAPE_ADDR_BITS'(SHAPE_DEPTH) - {1'b0, shape_idx}
                     : {1'b0, shape_idx};

    sqv_shape_rom u_shape_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign product      = PROD_BITS'(mult_a) * PROD_BITS'(mult_b);
    assign step_wide    = WIDE_BITS'(product) << oct_reg;
    assign gain_decayed = product[16 +: GAIN_BITS];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer) begin
                    if (in_op == OP_NOTE_ON) begin
                        state_next = S_ON_STEP;
                    end else if (in_op == OP_TICK) begin
                        state_next = sounding_reg ? S_SHAPE : S_EMIT;
                    end
                end
            end
            S_ON_STEP:  state_next = S_ON_LEVEL;
            S_ON_LEVEL: state_next = S_IDLE;
            S_SHAPE:    state_next = (gain_reg != '0) ? S_REL : S_EMIT;
            S_REL:      state_next = S_DECAY;
            S_DECAY:    state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        mult_a        = '0;
        mult_b        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_ON_STEP:
            begin
                mult_a = a4_reg;
                mult_b = semitone_ratio(semi_reg);
            end
            S_ON_LEVEL:
            begin
                mult_a = MULT_A_BITS'(scale_reg);
                mult_b = MULT_B_BITS'(vel_reg);
            end
            S_SHAPE:
            begin
                mult_a = MULT_A_BITS'(rom_data);
                mult_b = MULT_B_BITS'(level_reg);
            end
            S_REL:
            begin
                mult_a = MULT_A_BITS'(mag_reg);
                mult_b = gain_reg;
            end
            S_DECAY:
            begin
                mult_a = MULT_A_BITS'(decay_reg);
                mult_b = gain_reg;
            end
            S_EMIT:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        step_next     = step_reg;
        level_next    = level_reg;
        gain_next     = gain_reg;
        sounding_next = sounding_reg;
        oct_next      = oct_reg;
        semi_next     = semi_reg;
        vel_next      = vel_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        active_next   = active_reg;
        ended_next    = ended_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer) begin
                    unique case (in_op)
                        OP_NOTE_ON:
                        begin
                            phase_next    = '0;
                            gain_next     = '0;
                            sounding_next = 1'b1;
                            oct_next      = in_split.oct;
                            semi_next     = in_split.semi;
                            vel_next      = in_vel;
                        end
                        OP_RELEASE:
                        begin
                            if (sounding_reg && gain_reg == '0) begin
                                gain_next = GAIN_ONE;
                            end
                        end
                        OP_OFF:
                        begin
                            sounding_next = 1'b0;
                            step_next     = '0;
                            gain_next     = '0;
                        end
                        OP_TICK:
                        begin
                            mag_next    = '0;
                            neg_next    = phase_reg[PHASE_BITS-1] && sounding_reg;
                            active_next = sounding_reg;
                            ended_next  = 1'b0;
                        end
                        default:
                        begin
                            ended_next = 1'b0;
                        end
                    endcase
                end
            end
            S_ON_STEP:
            begin
                step_next = step_wide[STEP_SHIFT +: PHASE_BITS];
            end
            S_ON_LEVEL:
            begin
                level_next = product[VEL_BITS +: LEVEL_BITS];
            end
            S_SHAPE:
            begin
                mag_next   = product[16 +: SAMPLE_BITS];
                phase_next = phase_reg + step_reg;
            end
            S_REL:
            begin
                mag_next = product[16 +: SAMPLE_BITS];
            end
            S_DECAY:
            begin
                if (gain_decayed <= thr_reg) begin
                    sounding_next = 1'b0;
                    step_next     = '0;
                    gain_next     = '0;
                    ended_next    = 1'b1;
                end else begin
                    gain_next = gain_decayed;
                end
            end
            S_EMIT:
            begin
                neg_next = neg_reg;
            end
            default:
            begin
                neg_next = neg_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= S_IDLE;
            a4_reg       <= RST_A4_STEP;
            scale_reg    <= RST_LEVEL_SCALE;
            decay_reg    <= RST_DECAY;
            thr_reg      <= RST_THRESHOLD;
            phase_reg    <= '0;
            step_reg     <= '0;
            level_reg    <= '0;
            gain_reg     <= '0;
            sounding_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            level_reg    <= level_next;
            gain_reg     <= gain_next;
            sounding_reg <= sounding_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_A4_STEP:     a4_reg    <= cfg_data[PHASE_BITS-1:0];
                    CFG_LEVEL_SCALE: scale_reg <= cfg_data[LEVEL_BITS-1:0];
                    CFG_DECAY:       decay_reg <= cfg_data[FACTOR_BITS-1:0];
                    CFG_THRESHOLD:   thr_reg   <= cfg_data[GAIN_BITS-1:0];
                    default:         thr_reg   <= thr_reg;
                endcase
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        oct_reg    <= oct_next;
        semi_reg   <= semi_next;
        vel_reg    <= vel_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        active_reg <= active_next;
        ended_reg  <= ended_next;
        if (out_load) begin
            out_sample_reg <= neg_reg ? (SAMPLE_BITS'(0) - mag_reg) : mag_reg;
            out_active_reg <= active_reg;
            out_ended_reg  <= ended_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tuser  = out_active_reg;
    assign m_axis_tlast  = out_ended_reg;

    a_end_is_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("note end flagged on a silent sample");

    a_gain_needs_note: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg != '0 |-> sounding_reg)
        else $error("release gain running without a sounding note");

    a_idle_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        !sounding_reg |-> step_reg == '0)
        else $error("phase step left over on an idle voice");

    a_end_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sounding_reg) |-> $past(state_reg == S_DECAY)
            || $past(in_xfer && s_axis_tuser == OP_OFF))
        else $error("voice stopped without a release end or an immediate off");

endmodule
